// ===== rtl/bmpcs_pkg.sv =====
// ----------------------------------------------------------------------------
// bmpcs_pkg
// Shared types and constants for the bicubic mesh patch color sampler.
// ----------------------------------------------------------------------------
package bmpcs_pkg;

    // Configuration register indexes.
    localparam logic [2:0] CFG_ORIGIN_X = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y = 3'd1;
    localparam logic [2:0] CFG_SIZE_X   = 3'd2;
    localparam logic [2:0] CFG_SIZE_Y   = 3'd3;
    localparam logic [2:0] CFG_COLUMNS  = 3'd4;
    localparam logic [2:0] CFG_ROWS     = 3'd5;

    // Request operation codes.
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam int unsigned COLOR_BITS = 64;

    typedef struct packed {
        logic        opcode;
        logic [5:0]  patch_index;
        logic [1:0]  point_row;
        logic [1:0]  point_col;
        logic [15:0] red_in;
        logic [15:0] green_in;
        logic [15:0] blue_in;
        logic [15:0] alpha_in;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
    } t_req;

    typedef struct packed {
        logic [15:0] red_out;
        logic [15:0] green_out;
        logic [15:0] blue_out;
        logic [15:0] alpha_out;
    } t_rsp;

    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] data;
    } t_cfg;

endpackage

// ===== rtl/bmpcs_if.sv =====
// ----------------------------------------------------------------------------
// bmpcs_req_if / bmpcs_rsp_if / bmpcs_cfg_if
// Valid/ready channels for requests, results and register writes.
// ----------------------------------------------------------------------------
interface bmpcs_req_if;
    logic            valid;
    logic            ready;
    bmpcs_pkg::t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface bmpcs_rsp_if;
    logic            valid;
    logic            ready;
    bmpcs_pkg::t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface bmpcs_cfg_if;
    logic            valid;
    logic            ready;
    bmpcs_pkg::t_cfg payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/bmpcs_ram.sv =====
// ----------------------------------------------------------------------------
// bmpcs_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module bmpcs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/bicubic_mesh_patch_color_sampler.sv =====
// ----------------------------------------------------------------------------
// bicubic_mesh_patch_color_sampler
// Stores bicubic patch control colors and returns tensor Bernstein-weighted
// color samples, using one shared divider and one shared multiplier.
// ----------------------------------------------------------------------------
// Channel   Direction  Accepted when          Carries
// i_req     sink       valid && ready         write or sample request
// o_rsp     source     valid && ready         one RGBA result per sample
// i_cfg     sink       valid && ready         register index and data
//
// A write is stored as it is accepted and the block stays ready. A sample runs
// two bit serial divides (49 quotient bits each), then local coordinates, the
// Bernstein weights and the patch base, then the 16 control points (read
// address, weight product beside the memory read, four channel products), then
// rounding of the four channels, and is not overlapped with the next request.
// An empty, zero-sized or oversized mesh returns a zero result without dividing.
// Reset is synchronous, active low, and clears control state; the color
// memory is not cleared. A stalled result holds; no request is taken meanwhile.
// ----------------------------------------------------------------------------
module bicubic_mesh_patch_color_sampler #(
    parameter int MAX_PATCHES  = 64,
    parameter int CHANNEL_BITS = 16
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    bmpcs_req_if.sink   i_req,
    bmpcs_rsp_if.source o_rsp,
    bmpcs_cfg_if.sink   i_cfg
);
    localparam int DEPTH = MAX_PATCHES * 16;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [15:0] CH_MAX = 16'((32'd1 << CHANNEL_BITS) - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DIVX, S_DIVY, S_LOC, S_BERN, S_BASE, S_RD, S_WMUL, S_CMUL,
        S_ROUND, S_OUT
    } t_state;

    // Configuration registers.
    logic signed [31:0] r_org_x, r_org_y, r_size_x, r_size_y;
    logic [6:0]         r_cols, r_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0; r_org_y <= '0; r_size_x <= '0; r_size_y <= '0;
            r_cols <= '0; r_rows <= '0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.payload.index)
                bmpcs_pkg::CFG_ORIGIN_X: r_org_x  <= i_cfg.payload.data;
                bmpcs_pkg::CFG_ORIGIN_Y: r_org_y  <= i_cfg.payload.data;
                bmpcs_pkg::CFG_SIZE_X:   r_size_x <= i_cfg.payload.data;
                bmpcs_pkg::CFG_SIZE_Y:   r_size_y <= i_cfg.payload.data;
                bmpcs_pkg::CFG_COLUMNS:  r_cols   <= i_cfg.payload.data[6:0];
                bmpcs_pkg::CFG_ROWS:     r_rows   <= i_cfg.payload.data[6:0];
                default: ;
            endcase
        end
    end
    assign i_cfg.ready = 1'b1;

    t_state r_state;

    // Control color memory.
    logic              w_we;
    logic [AW-1:0]     w_waddr, r_raddr;
    logic [63:0]       w_wdata, w_rdata;
    logic [15:0]       w_mask;

    assign w_mask  = CH_MAX;
    assign w_we    = i_req.valid && i_req.ready &&
                     (i_req.payload.opcode == bmpcs_pkg::OP_WRITE) &&
                     ({26'd0, i_req.payload.patch_index} < 32'(MAX_PATCHES));
    assign w_waddr = AW'({i_req.payload.patch_index, i_req.payload.point_row,
                          i_req.payload.point_col});
    assign w_wdata = {i_req.payload.alpha_in & w_mask, i_req.payload.blue_in & w_mask,
                      i_req.payload.green_in & w_mask, i_req.payload.red_in & w_mask};

    bmpcs_ram #(.WIDTH(bmpcs_pkg::COLOR_BITS), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(r_raddr),
        .o_rdata(w_rdata)
    );

    // Sample working registers.
    logic signed [31:0] r_px, r_py;
    logic [48:0]  r_rem;      // divider remainder
    logic [48:0]  r_num;      // divider dividend shift register
    logic [31:0]  r_den;      // divider magnitude of size
    logic [5:0]   r_cnt;
    logic         r_zero;     // quotient is forced to zero
    logic [16:0]  r_u, r_v;
    logic [16:0]  r_lu, r_lv;
    logic [6:0]   r_cx, r_cy;
    logic [16:0]  r_bu [4];
    logic [16:0]  r_bv [4];
    logic [2:0]   r_bstep;
    logic         r_bdir;     // 0: u direction, 1: v direction
    logic [1:0]   r_bk;
    logic [47:0]  r_t1, r_t2; // Bernstein partial products
    logic [AW-1:0] r_base;
    logic [3:0]   r_pt;
    logic [1:0]   r_ch;
    logic [33:0]  r_w;
    logic [63:0]  r_col;
    logic [63:0]  r_acc [4];
    logic [15:0]  r_res [4];

    // Shared multiplier, 34 x 34 bit unsigned; product registered per step.
    logic [33:0] w_ma, w_mb;
    logic [67:0] w_mp;
    assign w_mp = w_ma * w_mb;

    // Bernstein schedule selectors.
    logic [16:0] w_t, w_it;
    assign w_t  = r_bdir ? r_lv : r_lu;
    assign w_it = 17'h10000 - w_t;

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_LOC: begin
                w_ma = 34'(r_bdir ? r_v : r_u);
                w_mb = 34'(r_bdir ? r_rows : r_cols);
            end
            S_BERN: begin
                case (r_bstep)
                    3'd0: begin
                        w_ma = 34'(r_bk >= 2'd2 ? w_t : w_it);
                        w_mb = 34'(r_bk >= 2'd1 && r_bk != 2'd3 ? 17'(w_t) : 17'(w_it));
                        if (r_bk == 2'd0) w_mb = 34'(w_it);
                        if (r_bk == 2'd3) w_mb = 34'(w_t);
                        if (r_bk == 2'd1) begin w_ma = 34'(w_it); w_mb = 34'(w_it); end
                        if (r_bk == 2'd2) begin w_ma = 34'(w_it); w_mb = 34'(w_t); end
                    end
                    default: begin
                        w_ma = r_t1[33:0];
                        w_mb = 34'((r_bk == 2'd0 || r_bk == 2'd1) && r_bk != 2'd1
                                   ? w_it : ((r_bk == 2'd3 || r_bk == 2'd2) ? w_t : w_t));
                        if (r_bk == 2'd0) w_mb = 34'(w_it);
                    end
                endcase
            end
            S_BASE: begin
                w_ma = 34'(r_cy);
                w_mb = 34'(r_cols);
            end
            S_WMUL: begin
                w_ma = 34'(r_bu[r_pt[1:0]]);
                w_mb = 34'(r_bv[r_pt[3:2]]);
            end
            S_CMUL: begin
                // The first channel comes straight from the memory read.
                w_ma = 34'((r_ch == 2'd0) ? w_rdata[15:0] : r_col[16*r_ch +: 16]);
                w_mb = r_w;
            end
            default: ;
        endcase
    end

    // Divider setup values: x when a sample starts, y when the x quotient ends.
    logic signed [32:0] w_dx, w_dy, w_d;
    logic signed [31:0] w_s;
    logic [32:0] w_ad;
    logic [31:0] w_as;
    logic        w_dz;
    assign w_dx = 33'(r_px) - 33'(r_org_x);
    assign w_dy = 33'(r_py) - 33'(r_org_y);
    assign w_d  = (r_cnt == 6'd0) ? w_dx : w_dy;
    assign w_s  = (r_cnt == 6'd0) ? r_size_x : r_size_y;
    assign w_ad = w_d[32] ? 33'(-w_d) : 33'(w_d);
    assign w_as = w_s[31] ? 32'(-w_s) : 32'(w_s);
    assign w_dz = (w_ad == '0) || (w_d[32] != w_s[31]);

    // One restoring divide step.
    logic [49:0] w_trial;
    logic [48:0] w_rem_sh;
    assign w_rem_sh = {r_rem[47:0], r_num[48]};
    assign w_trial  = {1'b0, w_rem_sh} - {18'd0, r_den};

    logic [16:0] w_qclamp;
    assign w_qclamp = (r_num[48:17] != '0) ? 17'h10000 :
                      ((r_num[16:0] > 17'h10000) ? 17'h10000 : r_num[16:0]);

    // Bad mesh check.
    logic w_bad;
    assign w_bad = (r_cols == '0) || (r_rows == '0) || (r_size_x == '0) ||
                   (r_size_y == '0) || (32'(r_cols) * 32'(r_rows) > 32'(MAX_PATCHES));

    logic [6:0]  w_cmax, w_cell, w_gint;
    logic [23:0] w_g;
    assign w_g    = w_mp[23:0];
    assign w_gint = w_g[22:16];
    assign w_cmax = (r_bdir ? r_rows : r_cols) - 7'd1;
    assign w_cell = (w_gint > w_cmax) ? w_cmax : w_gint;

    // A raw Bernstein term reaches 2^48 at the ends of the patch.
    logic [16:0] w_bres;
    logic [48:0] w_braw;
    assign w_braw = (r_bk == 2'd1 || r_bk == 2'd2) ? 49'(w_mp[48:0] * 49'd3) : w_mp[48:0];
    assign w_bres = 17'((w_braw + 49'h8000_0000) >> 32);

    logic [63:0] w_rnd;
    assign w_rnd = (r_acc[r_ch] + 64'h8000_0000) >> 32;

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = (r_state == S_OUT);
    assign o_rsp.payload.red_out   = r_res[0];
    assign o_rsp.payload.green_out = r_res[1];
    assign o_rsp.payload.blue_out  = r_res[2];
    assign o_rsp.payload.alpha_out = r_res[3];

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid && i_req.payload.opcode == bmpcs_pkg::OP_SAMPLE) begin
                        r_px <= i_req.payload.point_x;
                        r_py <= i_req.payload.point_y;
                        r_cnt <= '0;
                        r_state <= S_DIVX;
                    end
                end
                S_DIVX, S_DIVY: begin
                    if (w_bad) begin
                        for (int c = 0; c < 4; c++) r_res[c] <= '0;
                        r_state <= S_OUT;
                    end else if (r_cnt == 6'd0 || r_cnt == 6'd50) begin
                        if (r_cnt == 6'd50) begin
                            if (r_state == S_DIVX) r_u <= r_zero ? '0 : w_qclamp;
                            else r_v <= r_zero ? '0 : w_qclamp;
                        end
                        if (r_cnt == 6'd50 && r_state == S_DIVY) begin
                            r_bdir <= 1'b0;
                            r_state <= S_LOC;
                        end else begin
                            // Load the next coordinate (x first, then y).
                            r_num <= {w_ad, 16'd0};
                            r_den <= w_as;
                            r_zero <= w_dz;
                            r_rem <= '0;
                            r_cnt <= 6'd1;
                            if (r_cnt == 6'd50) r_state <= S_DIVY;
                        end
                    end else begin
                        if (!w_trial[49]) begin
                            r_rem <= w_trial[48:0];
                            r_num <= {r_num[47:0], 1'b1};
                        end else begin
                            r_rem <= w_rem_sh;
                            r_num <= {r_num[47:0], 1'b0};
                        end
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_LOC: begin
                    if (r_bdir) begin
                        r_cy <= w_cell;
                        r_lv <= 17'(w_g - {w_cell, 16'd0});
                        r_bdir <= 1'b0; r_bk <= '0; r_bstep <= '0;
                        r_state <= S_BERN;
                    end else begin
                        r_cx <= w_cell;
                        r_lu <= 17'(w_g - {w_cell, 16'd0});
                        r_bdir <= 1'b1;
                    end
                end
                S_BERN: begin
                    if (r_bstep == 3'd0) begin
                        r_t1 <= w_mp[47:0];
                        r_bstep <= 3'd1;
                    end else begin
                        if (r_bdir) r_bv[r_bk] <= w_bres;
                        else r_bu[r_bk] <= w_bres;
                        r_bstep <= 3'd0;
                        r_bk <= r_bk + 2'd1;
                        if (r_bk == 2'd3) begin
                            if (r_bdir) r_state <= S_BASE;
                            r_bdir <= ~r_bdir;
                        end
                    end
                end
                S_BASE: begin
                    r_base <= AW'((w_mp[12:0] + 13'(r_cx)) << 4);
                    r_pt <= '0;
                    for (int c = 0; c < 4; c++) r_acc[c] <= '0;
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_raddr <= r_base + AW'(r_pt);
                    r_state <= S_WMUL;
                end
                S_WMUL: begin
                    r_w <= w_mp[33:0];
                    r_ch <= '0;
                    r_state <= S_CMUL;
                end
                S_CMUL: begin
                    // The channel counter wraps to zero after the last channel.
                    if (r_ch == 2'd0) r_col <= w_rdata;
                    r_acc[r_ch] <= r_acc[r_ch] + w_mp[63:0];
                    r_ch <= r_ch + 2'd1;
                    if (r_ch == 2'd3) begin
                        r_pt <= r_pt + 4'd1;
                        if (r_pt == 4'd15) begin
                            r_state <= S_ROUND;
                        end else begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_ROUND: begin
                    r_res[r_ch] <= (w_rnd > 64'(CH_MAX)) ? CH_MAX : w_rnd[15:0];
                    r_ch <= r_ch + 2'd1;
                    if (r_ch == 2'd3) r_state <= S_OUT;
                end
                S_OUT: begin
                    if (o_rsp.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== tb/tb_bicubic_mesh_patch_color_sampler.sv =====
// ----------------------------------------------------------------------------
// tb_bicubic_mesh_patch_color_sampler
// This bench loads control colors into the patch store, samples points across
// several mesh setups and compares every RGBA result with its own predictor.
// ----------------------------------------------------------------------------
module tb_bicubic_mesh_patch_color_sampler;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk;
    logic i_rst_n;
    bmpcs_req_if req_ch();
    bmpcs_rsp_if rsp_ch();
    bmpcs_cfg_if cfg_ch();

    bicubic_mesh_patch_color_sampler u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // Predictor state: register copies and the control color store.
    logic signed [31:0] mdl_org_x, mdl_org_y, mdl_size_x, mdl_size_y;
    logic [6:0] mdl_cols, mdl_rows;
    logic [63:0] color_store [0:1023];
    bmpcs_pkg::t_rsp expected_colors[$];

    int errors = 0;
    int samples_checked = 0;
    int writes_sent = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Unit coordinate as a 1.16 fixed-point value clamped to one.
    function automatic longint unsigned unit_coord16(logic signed [31:0] p,
            logic signed [31:0] o, logic signed [31:0] s);
        longint d;
        longint sl;
        longint unsigned ad, as_, q;
        d = longint'(p) - longint'(o);
        sl = longint'(s);
        if (d == 0 || ((d < 0) != (sl < 0))) return 0;
        ad = (d < 0) ? -d : d;
        as_ = (sl < 0) ? -sl : sl;
        q = (ad << 16) / as_;
        return (q > 65536) ? 65536 : q;
    endfunction

    function automatic longint unsigned cell_local(longint unsigned t,
            longint unsigned cnt, output longint unsigned idx);
        longint unsigned g;
        g = t * cnt;
        idx = g >> 16;
        if (idx > cnt - 1) idx = cnt - 1;
        return g - (idx << 16);
    endfunction

    function automatic void cubic_weights(longint unsigned t,
            output longint unsigned b [4]);
        longint unsigned it;
        longint unsigned raw [4];
        it = 65536 - t;
        raw[0] = it * it * it;
        raw[1] = 3 * it * it * t;
        raw[2] = 3 * it * t * t;
        raw[3] = t * t * t;
        for (int k = 0; k < 4; k++) b[k] = (raw[k] + (64'd1 << 31)) >> 32;
    endfunction

    function automatic bmpcs_pkg::t_rsp predict_color(bmpcs_pkg::t_req r);
        bmpcs_pkg::t_rsp res;
        longint unsigned bu [4], bv [4];
        longint unsigned acc [4];
        longint unsigned lu, lv, px, py, base, w, e, q;
        res = '0;
        if (mdl_cols == 0 || mdl_rows == 0 || mdl_size_x == 0 || mdl_size_y == 0 ||
                mdl_cols * mdl_rows > 64) return res;
        lu = cell_local(unit_coord16(r.point_x, mdl_org_x, mdl_size_x), mdl_cols, px);
        lv = cell_local(unit_coord16(r.point_y, mdl_org_y, mdl_size_y), mdl_rows, py);
        cubic_weights(lu, bu);
        cubic_weights(lv, bv);
        base = (py * mdl_cols + px) * 16;
        for (int c = 0; c < 4; c++) acc[c] = 0;
        for (int j = 0; j < 4; j++)
            for (int i = 0; i < 4; i++) begin
                w = bu[i] * bv[j];
                e = color_store[(base + j * 4 + i) % 1024];
                for (int c = 0; c < 4; c++) acc[c] += ((e >> (16 * c)) & 16'hFFFF) * w;
            end
        for (int c = 0; c < 4; c++) begin
            q = (acc[c] + (64'd1 << 31)) >> 32;
            if (q > 65535) q = 65535;
            case (c)
                0: res.red_out = q[15:0];
                1: res.green_out = q[15:0];
                2: res.blue_out = q[15:0];
                default: res.alpha_out = q[15:0];
            endcase
        end
        return res;
    endfunction

    // Send one request and update the predictor when it is accepted.
    // Valid stays high after the accept so requests can follow back to back.
    task automatic send_request(bmpcs_pkg::t_req r);
        int unsigned addr;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.payload <= r;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        if (r.opcode == bmpcs_pkg::OP_WRITE) begin
            addr = r.patch_index * 16 + r.point_row * 4 + r.point_col;
            color_store[addr] = {r.alpha_in, r.blue_in, r.green_in, r.red_in};
            writes_sent++;
        end else begin
            expected_colors.push_back(predict_color(r));
        end
        @(negedge i_clk);
    endtask

    // Register write; the caller drops valid after the last one.
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.payload <= '{index: idx, data: val};
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            bmpcs_pkg::CFG_ORIGIN_X: mdl_org_x = val;
            bmpcs_pkg::CFG_ORIGIN_Y: mdl_org_y = val;
            bmpcs_pkg::CFG_SIZE_X:   mdl_size_x = val;
            bmpcs_pkg::CFG_SIZE_Y:   mdl_size_y = val;
            bmpcs_pkg::CFG_COLUMNS:  mdl_cols = val[6:0];
            bmpcs_pkg::CFG_ROWS:     mdl_rows = val[6:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Stop sending, wait for outstanding samples, then let the block settle.
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (expected_colors.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
    endtask

    task automatic set_mesh(logic [31:0] ox, logic [31:0] oy, logic [31:0] sx,
            logic [31:0] sy, logic [6:0] cols, logic [6:0] rows);
        drain();
        write_reg(bmpcs_pkg::CFG_ORIGIN_X, ox);
        write_reg(bmpcs_pkg::CFG_ORIGIN_Y, oy);
        write_reg(bmpcs_pkg::CFG_SIZE_X, sx);
        write_reg(bmpcs_pkg::CFG_SIZE_Y, sy);
        write_reg(bmpcs_pkg::CFG_COLUMNS, {25'd0, cols});
        write_reg(bmpcs_pkg::CFG_ROWS, {25'd0, rows});
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic bmpcs_pkg::t_req color_write(int patch, int row, int col);
        bmpcs_pkg::t_req r;
        r = '0;
        r.opcode = bmpcs_pkg::OP_WRITE;
        r.patch_index = 6'(patch);
        r.point_row = 2'(row);
        r.point_col = 2'(col);
        r.red_in = 16'($urandom);
        r.green_in = 16'($urandom);
        r.blue_in = 16'($urandom);
        r.alpha_in = 16'($urandom);
        r.point_x = $urandom;
        r.point_y = $urandom;
        return r;
    endfunction

    function automatic bmpcs_pkg::t_req sample_at(logic [31:0] x, logic [31:0] y);
        bmpcs_pkg::t_req r;
        r = color_write($urandom_range(63), $urandom_range(3), $urandom_range(3));
        r.opcode = bmpcs_pkg::OP_SAMPLE;
        r.point_x = x;
        r.point_y = y;
        return r;
    endfunction

    // Random point, mostly inside the area, sometimes outside or extreme.
    function automatic logic [31:0] rand_coord(logic [31:0] o, logic [31:0] s);
        int unsigned k;
        k = $urandom_range(9);
        if (k == 0) return $urandom;
        if (k == 1) return o;
        if (k == 2) return o + s;
        return 32'(longint'($signed(o)) + longint'($signed(s)) *
                   longint'($urandom_range(1100)) / 1000 - 256);
    endfunction

    // Fill every control color so that any sample reads written entries.
    task automatic test_fill_store();
        bmpcs_pkg::t_req r;
        for (int p = 0; p < 64; p++)
            for (int k = 0; k < 16; k++) begin
                r = color_write(p, k / 4, k % 4);
                if (p == 0 && k == 0) begin
                    r.red_in = 16'hFFFF; r.green_in = 16'hFFFF;
                    r.blue_in = 16'hFFFF; r.alpha_in = 16'hFFFF;
                end
                if (p == 0 && k == 1) begin
                    r.red_in = '0; r.green_in = '0; r.blue_in = '0; r.alpha_in = '0;
                end
                send_request(r);
            end
    endtask

    // Directed: empty and oversized meshes, corners, extreme points.
    task automatic test_directed();
        bmpcs_pkg::t_req r;
        set_mesh(0, 0, 0, 32'h0001_0000, 1, 1);
        send_request(sample_at(32'h8000, 32'h8000));
        set_mesh(0, 0, 32'h0001_0000, 32'h0001_0000, 0, 4);
        send_request(sample_at(32'h8000, 32'h8000));
        set_mesh(0, 0, 32'h0001_0000, 32'h0001_0000, 9, 8);
        send_request(sample_at(32'h8000, 32'h8000));
        set_mesh(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 64, 1);
        send_request(sample_at(32'h7FFF_FFFF, 32'h8000_0000));
        send_request(sample_at(32'h8000_0000, 32'h7FFF_FFFF));
        send_request(sample_at(32'h0, 32'h0));
        set_mesh(32'h0001_0000, 32'hFFFF_0000, 32'h0004_0000, 32'h0004_0000, 8, 8);
        send_request(sample_at(32'h0001_0000, 32'hFFFF_0000));
        send_request(sample_at(32'h0005_0000, 32'h0003_0000));
        send_request(sample_at(32'h0003_0000, 32'h0001_0000));
        send_request(sample_at(32'h0000_0000, 32'hFFFE_0000));
        // Writes with full-scale channels, then sample the touched patch.
        r = color_write(63, 3, 3);
        r.red_in = 16'hFFFF; r.green_in = 0; r.blue_in = 16'hFFFF; r.alpha_in = 0;
        send_request(r);
        set_mesh(0, 0, 32'h0001_0000, 32'h0001_0000, 1, 64);
        send_request(sample_at(32'h0001_0000, 32'h0001_0000));
        send_request(sample_at(32'h0000_8000, 32'h0000_0400));
    endtask

    task automatic test_random(int count);
        logic [6:0] cols, rows;
        logic [31:0] sx, sy, ox, oy;
        for (int n = 0; n < count; n++) begin
            if (n % 150 == 0) begin
                cols = 7'($urandom_range(1, 8));
                rows = 7'($urandom_range(1, 64 / cols));
                if ($urandom_range(9) == 0) cols = 7'($urandom_range(0, 64));
                ox = $urandom_range(1) ? $urandom : $urandom_range(32'h40000);
                oy = $urandom_range(1) ? $urandom : $urandom_range(32'h40000);
                sx = $urandom_range(3) == 0 ? -$urandom_range(32'h80000, 1) :
                     $urandom_range(32'h80000, 1);
                sy = $urandom_range(3) == 0 ? -$urandom_range(32'h80000, 1) :
                     $urandom_range(32'h80000, 1);
                set_mesh(ox, oy, sx, sy, cols, rows);
            end
            if ($urandom_range(4) == 0)
                send_request(color_write($urandom_range(63), $urandom_range(3),
                                         $urandom_range(3)));
            else
                send_request(sample_at(rand_coord(mdl_org_x, mdl_size_x),
                                       rand_coord(mdl_org_y, mdl_size_y)));
        end
    endtask

    // Stall the result side long enough to back up the input.
    task automatic test_backpressure();
        hold_cycles = 400;
        for (int n = 0; n < 12; n++)
            send_request(sample_at(rand_coord(mdl_org_x, mdl_size_x),
                                   rand_coord(mdl_org_y, mdl_size_y)));
    endtask

    // Result ready with random stalls and a counted hold-off.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        bmpcs_pkg::t_rsp exp_c;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_colors.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, rsp_ch.payload);
                errors++;
            end else begin
                exp_c = expected_colors.pop_front();
                samples_checked++;
                if (exp_c.red_out !== rsp_ch.payload.red_out)
                    $display("%0t: red expected %h actual %h", $realtime,
                             exp_c.red_out, rsp_ch.payload.red_out);
                if (exp_c.green_out !== rsp_ch.payload.green_out)
                    $display("%0t: green expected %h actual %h", $realtime,
                             exp_c.green_out, rsp_ch.payload.green_out);
                if (exp_c.blue_out !== rsp_ch.payload.blue_out)
                    $display("%0t: blue expected %h actual %h", $realtime,
                             exp_c.blue_out, rsp_ch.payload.blue_out);
                if (exp_c.alpha_out !== rsp_ch.payload.alpha_out)
                    $display("%0t: alpha expected %h actual %h", $realtime,
                             exp_c.alpha_out, rsp_ch.payload.alpha_out);
                if (exp_c !== rsp_ch.payload) errors++;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.payload = '0;
        mdl_org_x = 0; mdl_org_y = 0; mdl_size_x = 0; mdl_size_y = 0;
        mdl_cols = 0; mdl_rows = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_fill_store();
        test_directed();
        test_random(225);
        send_idle_pct = 76;
        test_random(225);
        send_idle_pct = 0;
        recv_stall_pct = 76;
        test_random(225);
        send_idle_pct = 12;
        recv_stall_pct = 12;
        test_random(225);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_backpressure();
        drain();
        $display("Covered %0d color writes and %0d checked samples over", writes_sent,
                 samples_checked);
        $display("empty, oversized, flipped and random meshes with idling and stalls.");
        if (errors == 0 && expected_colors.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule
